// File: sv/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shorthand for the concurrent checks of the double-ended queue.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_ended_queue: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_ended_queue: check failed");

`endif

// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Types, codes and field widths shared by the queue and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int DefDepth     = 1024;
  localparam int DefElemWidth = 32;

  localparam int OpWidth      = 3;
  localparam int ValueWidth   = 32;
  localparam int PosWidth     = 10;
  localparam int StatusWidth  = 2;
  localparam int LenWidth     = 11;
  localparam int InDataWidth  = 48;
  localparam int OutDataWidth = 48;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

`default_nettype wire

// File: sv/deq_ram.sv
// ----------------------------------------------------------------------------
// Double-ended queue element memory
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32,
  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] addr_i,
  input  wire logic [Width-1:0]     wdata_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque with push and pop at both ends and indexed reads.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH elements in one single-port RAM addressed as a
// ring from the head pointer. Each request gives exactly one response with
// the popped or read value, a status and the length after the request. One
// request is handled at a time. A push, a refused request or an unknown
// operation is answered directly, because the RAM write and the response
// register load happen at the same edge. A pop or a read is answered
// through the registered RAM read port followed by the response register.
// A new request is taken while the previous response is being drained.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH         = DefDepth,
  parameter int ELEMENT_WIDTH = DefElemWidth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // operation [2:0], push_value [34:3], position [44:35], zero fill [47:45]
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // value_out [31:0], status [33:32], length_out [44:34], zero fill [47:45]
  output logic      [OutDataWidth-1:0] m_axis_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int LW = (CW > PosWidth) ? CW : PosWidth;

  state_e                  state_q, state_d;
  logic   [AW-1:0]         head_q, head_d;
  logic   [CW-1:0]         count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  logic   [ValueWidth-1:0] value_q, value_d;
  status_e                 status_q, status_d;
  logic   [LenWidth-1:0]   len_q;
  logic                    load_res;

  op_e                     op;
  logic   [ValueWidth-1:0] push_value;
  logic   [PosWidth-1:0]   position;
  logic                    in_fire;

  logic                    full, empty, in_range;
  logic   [AW-1:0]         head_inc, head_dec;
  logic   [CW-1:0]         offset;
  logic   [SW-1:0]         slot_sum;
  logic   [AW-1:0]         slot;

  logic                    ram_we, ram_re;
  logic   [AW-1:0]         ram_addr;
  logic   [ELEMENT_WIDTH-1:0] ram_rdata;

  assign op         = op_e'(s_axis_tdata[2:0]);
  assign push_value = s_axis_tdata[34:3];
  assign position   = s_axis_tdata[44:35];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign in_range = (LW'(position) < LW'(count_q));
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  always_comb begin
    case (op)
      OP_PUSH_TAIL: offset = count_q;
      OP_POP_TAIL:  offset = count_q - CW'(1);
      default:      offset = CW'(position);
    endcase
  end

  assign slot_sum = {1'b0, head_q} + SW'(offset);
  assign slot     = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    load_res    = 1'b0;
    value_d     = '0;
    status_d    = STATUS_OK;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = slot;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_PUSH_HEAD: begin
              load_res = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we   = 1'b1;
                ram_addr = head_dec;
                head_d   = head_dec;
                count_d  = count_q + CW'(1);
              end
            end
            OP_PUSH_TAIL: begin
              load_res = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_POP_HEAD: begin
              if (empty) begin
                load_res = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                ram_re   = 1'b1;
                ram_addr = head_q;
                head_d   = head_inc;
                count_d  = count_q - CW'(1);
                state_d  = S_READ;
              end
            end
            OP_POP_TAIL: begin
              if (empty) begin
                load_res = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                ram_re  = 1'b1;
                count_d = count_q - CW'(1);
                state_d = S_READ;
              end
            end
            OP_READ: begin
              if (!in_range) begin
                load_res = 1'b1;
                status_d = STATUS_EMPTY;
              end else begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end
            end
            default: begin
              load_res = 1'b1;
              status_d = STATUS_EMPTY;
            end
          endcase
        end
      end
      S_READ: begin
        load_res = 1'b1;
        value_d  = ValueWidth'(ram_rdata);
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      value_q  <= value_d;
      status_q <= status_d;
      len_q    <= LenWidth'(count_d);
    end
  end

  deq_ram #(
    .Depth(DEPTH),
    .Width(ELEMENT_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ELEMENT_WIDTH'(push_value)),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataWidth - LenWidth - StatusWidth - ValueWidth)'(0),
                          len_q, status_q, value_q};

endmodule

`default_nettype wire

// File: sv/deq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level checks on the double-ended queue, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_checker
  import deq_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tvalid,
  input wire logic                    s_axis_tready,
  input wire logic [InDataWidth-1:0]  s_axis_tdata,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata
);

  logic in_fire;
  logic out_stall;
  logic not_ok;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign not_ok    = m_axis_tvalid && (m_axis_tdata[33:32] != STATUS_OK);

  // A stalled response stays valid and unchanged.
  `DEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid)
  `DEQ_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata))

  // A failed request never returns element data.
  `DEQ_ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, not_ok, m_axis_tdata[31:0] == '0)

  // After a request either its response is shown or the queue stops taking requests.
  `DEQ_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_fire, m_axis_tvalid || !s_axis_tready)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire
